@@ rtl/aescc_pkg.sv @@
package aescc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEXP,
    ST_INVK,
    ST_RUN,
    ST_OUT
  } state_t;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_FWD  = 2'd1;
  localparam logic [1:0] CMD_INV  = 2'd2;

  localparam logic [2:0] REG_KEY0  = 3'd0;
  localparam logic [2:0] REG_KEY1  = 3'd1;
  localparam logic [2:0] REG_KEY2  = 3'd2;
  localparam logic [2:0] REG_KEY3  = 3'd3;
  localparam logic [2:0] REG_KSIZE = 3'd4;
  localparam logic [2:0] REG_CHAIN = 3'd5;

  typedef struct packed {
    logic kexp_start;
    logic kexp_step;
    logic invk_start;
    logic invk_step;
    logic blk_start;
    logic blk_step;
    logic load;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic kexp_done;
    logic invk_done;
    logic blk_done;
  } dp_stat_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h00;
    p = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ p;
      p = xtime(p);
    end
    gmul = r;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] p;
    logic [7:0] r;
    p = x;
    r = 8'h01;
    for (int i = 0; i < 7; i++) begin
      p = gmul(p, p);
      r = gmul(r, p);
    end
    ginv = r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
    rotl8 = (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] b;
    b = ginv(x);
    sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] isbox_calc(input logic [7:0] s);
    isbox_calc = ginv(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
  endfunction

  function automatic logic [255:0][7:0] mk_sbox(input logic inv);
    logic [255:0][7:0] t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inv ? isbox_calc(8'(i)) : sbox_calc(8'(i));
    end
    mk_sbox = t;
  endfunction

  localparam logic [255:0][7:0] SBOX  = mk_sbox(1'b0);
  localparam logic [255:0][7:0] ISBOX = mk_sbox(1'b1);

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
    logic [7:0] a0, a1, a2, a3, m0, m1, m2, m3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    m0 = inv ? 8'd14 : 8'd2;
    m1 = inv ? 8'd11 : 8'd3;
    m2 = inv ? 8'd13 : 8'd1;
    m3 = inv ? 8'd9  : 8'd1;
    mix_col = {gmul(a0, m0) ^ gmul(a1, m1) ^ gmul(a2, m2) ^ gmul(a3, m3),
               gmul(a0, m3) ^ gmul(a1, m0) ^ gmul(a2, m1) ^ gmul(a3, m2),
               gmul(a0, m2) ^ gmul(a1, m3) ^ gmul(a2, m0) ^ gmul(a3, m1),
               gmul(a0, m1) ^ gmul(a1, m2) ^ gmul(a2, m3) ^ gmul(a3, m0)};
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
    mix_cols = {mix_col(s[127:96], inv), mix_col(s[95:64], inv),
                mix_col(s[63:32], inv), mix_col(s[31:0], inv)};
  endfunction

  // byte i sits at bits 127-8i
  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
        t[127 - 8 * (r + 4 * c) -: 8] = inv ? ISBOX[s[127 - 8 * (r + 4 * src) -: 8]]
                                            : SBOX[s[127 - 8 * (r + 4 * src) -: 8]];
      end
    end
    sub_shift = t;
  endfunction

endpackage

@@ rtl/aescc_ram.sv @@
module aescc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/aescc_ctrl.sv @@
module aescc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  input  logic                out_stall,
  input  logic                keys_ready,
  output logic                in_stall,
  output logic                out_valid,
  output aescc_pkg::dp_cmd_t  cmd,
  input  aescc_pkg::dp_stat_t stat
);
  import aescc_pkg::*;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign in_stall  = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && out_stall;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_cmd == CMD_FWD || in_cmd == CMD_INV) begin
            if (keys_ready) begin
              cmd.blk_start = 1'b1;
              state_nxt = ST_RUN;
            end else begin
              cmd.kexp_start = 1'b1;
              state_nxt = ST_KEXP;
            end
          end
        end
      end
      ST_KEXP: begin
        cmd.kexp_step = 1'b1;
        if (stat.kexp_done) begin
          cmd.invk_start = 1'b1;
          state_nxt = ST_INVK;
        end
      end
      ST_INVK: begin
        cmd.invk_step = 1'b1;
        if (stat.invk_done) begin
          cmd.blk_start = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.blk_step = 1'b1;
        if (stat.blk_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r || !out_stall) begin
          cmd.out_load = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

@@ rtl/aescc_dp.sv @@
module aescc_dp #(
  parameter int MAX_ROUNDS = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [63:0]         cfg_data,
  input  logic [1:0]          in_cmd,
  input  logic [63:0]         in_data_hi,
  input  logic [63:0]         in_data_lo,
  input  logic                in_last_block,
  output logic [63:0]         out_hi,
  output logic [63:0]         out_lo,
  output logic                out_end_of_buffer,
  output logic                keys_ready,
  input  aescc_pkg::dp_cmd_t  cmd,
  output aescc_pkg::dp_stat_t stat
);
  import aescc_pkg::*;

  localparam int NKEYS = 2 * (MAX_ROUNDS + 1);
  localparam int AW    = $clog2(NKEYS);
  localparam int RW    = $clog2(MAX_ROUNDS + 1);

  logic [3:0][63:0] key_r;
  logic [1:0]       ksize_r;
  logic             mode_r, ready_r;
  logic [127:0]     chain_r;
  logic [127:0]     din_r;
  logic [1:0]       bcmd_r;
  logic             last_r;
  logic             eob_r;
  logic [RW-1:0]    nr_r;

  // key expansion: 32-bit word window of nk words
  logic [7:0][31:0] win_r;
  logic [5:0]       wi_r;
  logic [2:0]       kpos_r;
  logic [7:0]       rcon_r;
  logic [2:0]       nk_r;
  logic             half_r;
  logic [31:0]      hold_r;

  // ram ports
  logic          fwe, iwe;
  logic [AW-1:0] fwa, fra, iwa, ira;
  logic [63:0]   fwd, frd, iwd, ird;

  aescc_ram #(.WIDTH(64), .DEPTH(NKEYS)) u_fwd (
    .clk(clk), .we(fwe), .waddr(fwa), .wdata(fwd), .raddr(fra), .rdata(frd));
  aescc_ram #(.WIDTH(64), .DEPTH(NKEYS)) u_inv (
    .clk(clk), .we(iwe), .waddr(iwa), .wdata(iwd), .raddr(ira), .rdata(ird));

  // round counters
  logic [AW:0]   cnt_r;
  logic [RW-1:0] rnd_r;
  logic [1:0]    ph_r;
  logic [127:0]  st_r;
  logic [63:0]   kh_r;
  logic [63:0]   kl_r;
  logic [127:0]  res_r;
  logic          inv_use;

  assign keys_ready = ready_r;
  assign out_hi = res_r[127:64];
  assign out_lo = res_r[63:0];
  assign out_end_of_buffer = eob_r;

  // effective round count from key size
  logic [1:0]    ks_eff;
  logic [RW-1:0] nr_eff;
  always_comb begin
    ks_eff = (ksize_r == 2'd3) ? 2'd2 : ksize_r;
    if (ks_eff == 2'd2 && MAX_ROUNDS < 14) ks_eff = 2'd1;
    if (ks_eff == 2'd1 && MAX_ROUNDS < 12) ks_eff = 2'd0;
    nr_eff = RW'(10 + 2 * ks_eff);
  end

  // next expanded word
  logic [31:0] t_w, new_w;
  logic [2:0]  nk_last;
  always_comb begin
    nk_last = nk_r - 3'd1;
    t_w = win_r[nk_last];
    if (kpos_r == 3'd0) t_w = sub_word({t_w[23:0], t_w[31:24]}) ^ {rcon_r, 24'h0};
    else if (nk_r == 3'd0 && kpos_r == 3'd4) t_w = sub_word(t_w);
    new_w = win_r[0] ^ t_w;
  end

  logic [5:0] total_w;
  assign total_w = 6'(4 * (32'(nr_r) + 1));
  assign stat.kexp_done = cmd.kexp_step && (wi_r == total_w);

  // forward store writer: pairs of words
  logic [31:0] out_w;
  always_comb begin
    fwe = 1'b0;
    fwa = cnt_r[AW-1:0];
    out_w = (wi_r < {3'd0, nk_r == 3'd0 ? 3'd0 : nk_r}) ? win_r[wi_r[2:0]] : new_w;
    if (nk_r == 3'd0) out_w = (wi_r < 6'd8) ? win_r[wi_r[2:0]] : new_w;
    fwd = {hold_r, out_w};
    if (cmd.kexp_step && wi_r != total_w && half_r) fwe = 1'b1;
  end

  // inverse keys: read forward reversed, mix middle ones
  logic [AW-1:0] src_a;
  assign src_a = AW'((32'(nr_r) - 32'(cnt_r >> 1)) * 2 + 32'(cnt_r[0]));
  logic mid_key;
  logic [AW:0] icnt_r;
  assign mid_key = (icnt_r[AW:1] != 0) && (32'(icnt_r[AW:1]) != 32'(nr_r));
  // high half written from kh_r, low half in the following cycle from kl_r
  logic [127:0] ikey;
  assign ikey = mid_key ? mix_cols({kh_r, kl_r}, 1'b1) : {kh_r, kl_r};
  logic ivalid_r;
  assign stat.invk_done = cmd.invk_step && (32'(icnt_r) == 2 * (32'(nr_r) + 1));

  always_comb begin
    iwe = cmd.invk_step && ivalid_r && icnt_r[0];
    iwa = icnt_r[AW-1:0];
    iwd = ikey[63:0];
    if (cmd.invk_step && ivalid_r && !icnt_r[0] && !stat.invk_done) begin
      iwe = 1'b1;
      iwa = icnt_r[AW-1:0];
      iwd = ikey[127:64];
    end
  end

  // block reads: phase 0 reads hi, phase 1 lo, phase 2 apply
  always_comb begin
    fra = src_a;
    ira = '0;
    if (!(cmd.kexp_step || cmd.invk_step || cmd.kexp_start || cmd.invk_start)) begin
      fra = AW'(32'(rnd_r) * 2 + 32'(ph_r[0]));
      ira = fra;
    end
  end

  logic [127:0] rk, rstep;
  logic         final_r;
  assign rk = inv_use ? {kh_r, ird} : {kh_r, frd};
  assign final_r = (rnd_r == nr_r);
  always_comb begin
    rstep = sub_shift(st_r, inv_use);
    if (!final_r) rstep = mix_cols(rstep, inv_use);
  end
  assign stat.blk_done = cmd.blk_step && ph_r == 2'd2 && final_r;

  logic [127:0] enc_in;
  assign enc_in = mode_r ? chain_r : (bcmd_r == CMD_FWD ? din_r ^ chain_r : din_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      ksize_r <= '0;
      mode_r  <= 1'b0;
      ready_r <= 1'b0;
      chain_r <= '0;
      nr_r    <= RW'(10);
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
            key_r[cfg_idx[1:0]] <= cfg_data;
            ready_r <= 1'b0;
          end
          REG_KSIZE: begin
            ksize_r <= cfg_data[1:0];
            ready_r <= 1'b0;
          end
          REG_CHAIN: mode_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load && in_cmd == CMD_LOAD) chain_r <= {in_data_hi, in_data_lo};
      if (cmd.kexp_start) nr_r <= nr_eff;
      if (stat.invk_done) ready_r <= 1'b1;
      // chaining value moves on once the result has been formed
      if (cmd.out_load) begin
        if (mode_r) chain_r <= chain_r + 128'd1;
        else if (bcmd_r == CMD_FWD) chain_r <= st_r;
        else chain_r <= din_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      din_r  <= {in_data_hi, in_data_lo};
      bcmd_r <= in_cmd;
      last_r <= in_last_block;
    end
    if (cmd.kexp_start) begin
      for (int i = 0; i < 8; i++) begin
        win_r[i] <= (i % 2 == 0) ? key_r[i / 2][63:32] : key_r[i / 2][31:0];
      end
      nk_r   <= 3'(4 + 2 * ks_eff);
      wi_r   <= '0;
      kpos_r <= '0;
      rcon_r <= 8'h01;
      half_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.kexp_step && !stat.kexp_done) begin
      half_r <= ~half_r;
      hold_r <= out_w;
      if (half_r) cnt_r <= cnt_r + 1'b1;
      wi_r <= wi_r + 6'd1;
      if (wi_r >= {3'd0, nk_r == 3'd0 ? 3'd0 : nk_r} && !(nk_r == 3'd0 && wi_r < 6'd8)) begin
        for (int i = 0; i < 7; i++) win_r[i] <= win_r[i + 1];
        win_r[nk_last] <= new_w;
        if (kpos_r == 3'd0) rcon_r <= xtime(rcon_r);
        kpos_r <= (kpos_r == nk_last) ? 3'd0 : kpos_r + 3'd1;
      end
    end
    if (cmd.invk_start) begin
      cnt_r    <= '0;
      icnt_r   <= '0;
      ivalid_r <= 1'b0;
    end else if (cmd.invk_step) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r != 0 && cnt_r[0]) kh_r <= frd;
      if (cnt_r != 0 && !cnt_r[0]) begin
        kl_r     <= frd;
        ivalid_r <= 1'b1;
      end
      if (ivalid_r) icnt_r <= icnt_r + 1'b1;
    end
    if (cmd.blk_start) begin
      inv_use <= (cmd.load ? (in_cmd == CMD_INV) : (bcmd_r == CMD_INV)) && !mode_r;
      rnd_r   <= '0;
      ph_r    <= '0;
      st_r    <= cmd.load ? (mode_r ? chain_r
                 : (in_cmd == CMD_FWD ? {in_data_hi, in_data_lo} ^ chain_r
                                      : {in_data_hi, in_data_lo}))
                 : enc_in;
    end else if (cmd.blk_step) begin
      unique case (ph_r)
        2'd0: ph_r <= 2'd1;
        2'd1: begin
          ph_r <= 2'd2;
          kh_r <= inv_use ? ird : frd;
        end
        default: begin
          ph_r  <= 2'd0;
          rnd_r <= rnd_r + 1'b1;
          st_r  <= (rnd_r == 0) ? st_r ^ rk : rstep ^ rk;
        end
      endcase
    end
    if (cmd.out_load) begin
      res_r <= mode_r ? (st_r ^ din_r) : (bcmd_r == CMD_FWD ? st_r : st_r ^ chain_r);
      eob_r <= last_r;
    end
  end
endmodule

@@ rtl/aes_cbc_ctr_cipher_top.sv @@
// channel | valid     | stall     | payload
// input   | in_valid  | in_stall  | in_cmd, in_data_hi, in_data_lo, in_last_block
// result  | out_valid | out_stall | out_out_hi, out_out_lo, out_end_of_buffer
// a block runs each round as high key half read, low half read and apply, through one
// shared round unit and the one read port of the key store
// the first block after a key change first runs key expansion and the inverse key pass
// load and unused commands do not stall; reset clears keys_ready and chaining value
// a held result stalls the next block only at its end
module aes_cbc_ctr_cipher_top #(
  parameter int MAX_ROUNDS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_data_hi,
  input  logic [63:0] in_data_lo,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_out_hi,
  output logic [63:0] out_out_lo,
  output logic        out_end_of_buffer
);
  import aescc_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t dstat;
  logic     kready;

  // controller sequences expansion, inverse pass and rounds
  aescc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_cmd(in_cmd),
    .out_stall(out_stall), .keys_ready(kready), .in_stall(in_stall),
    .out_valid(out_valid), .cmd(dcmd), .stat(dstat));

  aescc_dp #(.MAX_ROUNDS(MAX_ROUNDS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_cmd(in_cmd), .in_data_hi(in_data_hi), .in_data_lo(in_data_lo),
    .in_last_block(in_last_block), .out_hi(out_out_hi), .out_lo(out_out_lo),
    .out_end_of_buffer(out_end_of_buffer), .keys_ready(kready), .cmd(dcmd), .stat(dstat));
endmodule
